// File: hdl/byte_stream_find_replace_core_defines.svh
// Assertion macros shared by the find-and-replace RTL.
`ifndef BYTE_STREAM_FIND_REPLACE_CORE_DEFINES_SVH
`define BYTE_STREAM_FIND_REPLACE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge outside reset.
`define BSFR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("find/replace check failed");

// Condition that must never be true outside reset.
`define BSFR_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("find/replace forbidden condition seen");

`else

`define BSFR_ASSERT(lbl, prop)
`define BSFR_NEVER(lbl, expr)

`endif

`endif

// File: hdl/bsfr_pkg.sv
// Shared constants and types of the byte stream find-and-replace core.
`timescale 1ns / 1ps
`default_nettype none

package bsfr_pkg;

    localparam int PATTERN_MAX     = 16;
    localparam int REPLACEMENT_MAX = 16;
    localparam int REG_BYTES       = 16;

    localparam int PAT_CAP = (PATTERN_MAX < REG_BYTES) ? PATTERN_MAX : REG_BYTES;
    localparam int REP_CAP = (REPLACEMENT_MAX < REG_BYTES) ? REPLACEMENT_MAX : REG_BYTES;

    localparam int LEN_W  = 5;
    localparam int IDX_W  = (PAT_CAP > 1) ? $clog2(PAT_CAP) : 1;
    localparam int RIDX_W = $clog2(REG_BYTES);
    localparam int TOT_W  = $clog2(PAT_CAP + REP_CAP + 1);

    localparam int CNT_W = 24;
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAT_LO  = 3'd0,
        REG_PAT_HI  = 3'd1,
        REG_PAT_LEN = 3'd2,
        REG_REP_LO  = 3'd3,
        REG_REP_HI  = 3'd4,
        REG_REP_LEN = 3'd5
    } cfg_reg_t;

    // Effective configuration as seen by the front and back ends.
    typedef struct packed {
        logic [REG_BYTES-1:0][7:0] pat;
        logic [REG_BYTES-1:0][7:0] rep;
        logic [LEN_W-1:0]          plen;
        logic [LEN_W-1:0]          rlen;
        logic                      clear_window;
    } cfg_t;

    // One classified input byte: literal bytes first, then the replacement.
    typedef struct packed {
        logic [PAT_CAP-1:0][7:0] lit;
        logic [LEN_W-1:0]        lit_cnt;
        logic                    rep;
        logic                    last;
        logic [CNT_W-1:0]        count;
    } cmd_t;

endpackage

`default_nettype wire

// File: hdl/bsfr_in_if.sv
// Input channel of the find-and-replace core: one stream byte per word.
`timescale 1ns / 1ps
`default_nettype none

interface bsfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_last;

    modport source (output valid, output in_byte, output is_last, input ready);
    modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

`default_nettype wire

// File: hdl/bsfr_out_if.sv
// Output channel of the find-and-replace core: one result per word.
`timescale 1ns / 1ps
`default_nettype none

interface bsfr_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        run_last;
    logic        end_of_stream;
    logic [23:0] replacement_count;

    modport source (output valid, output out_byte, output byte_valid, output run_last,
                    output end_of_stream, output replacement_count, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input run_last,
                    input end_of_stream, input replacement_count, output ready);
endinterface

`default_nettype wire

// File: hdl/bsfr_cfg_regs.sv
// Configuration registers and effective pattern and replacement lengths.
`timescale 1ns / 1ps
`default_nettype none

module bsfr_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [bsfr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bsfr_pkg::CFG_DATA_W-1:0]  cfg_data,
    output bsfr_pkg::cfg_t                   cfg
);
    import bsfr_pkg::*;

    logic [CFG_DATA_W-1:0] pat_lo_reg, pat_hi_reg, rep_lo_reg, rep_hi_reg;
    logic [LEN_W-1:0]      plen_reg, rlen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_lo_reg <= '0;
            pat_hi_reg <= '0;
            rep_lo_reg <= '0;
            rep_hi_reg <= '0;
            plen_reg   <= LEN_W'(1);
            rlen_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PAT_LO:  pat_lo_reg <= cfg_data;
                REG_PAT_HI:  pat_hi_reg <= cfg_data;
                REG_PAT_LEN: plen_reg   <= cfg_data[LEN_W-1:0];
                REG_REP_LO:  rep_lo_reg <= cfg_data;
                REG_REP_HI:  rep_hi_reg <= cfg_data;
                REG_REP_LEN: rlen_reg   <= cfg_data[LEN_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        cfg.pat = {pat_hi_reg, pat_lo_reg};
        cfg.rep = {rep_hi_reg, rep_lo_reg};
        // A zero pattern length behaves as one; both lengths clip at the byte capacity.
        if (plen_reg == '0)
            cfg.plen = LEN_W'(1);
        else if (plen_reg > LEN_W'(PAT_CAP))
            cfg.plen = LEN_W'(PAT_CAP);
        else
            cfg.plen = plen_reg;
        if (rlen_reg > LEN_W'(REP_CAP))
            cfg.rlen = LEN_W'(REP_CAP);
        else
            cfg.rlen = rlen_reg;
        cfg.clear_window = cfg_we && (cfg_reg_t'(cfg_index) == REG_PAT_LEN);
    end

endmodule

`default_nettype wire

// File: hdl/bsfr_front.sv
// Front end: takes stream bytes, tracks the pending window and classifies each byte.
`timescale 1ns / 1ps
`default_nettype none
`include "byte_stream_find_replace_core_defines.svh"

module bsfr_front (
    input  logic           clk,
    input  logic           rst_n,
    bsfr_in_if.sink        in_ch,
    input  bsfr_pkg::cfg_t cfg,
    input  logic           full,
    output logic           push,
    output bsfr_pkg::cmd_t cmd
);
    import bsfr_pkg::*;

    logic [PAT_CAP-1:0][7:0] win_reg, win_next;
    logic [LEN_W-1:0]        fill_reg, fill_next;
    logic [CNT_W-1:0]        count_reg, count_next;

    logic [PAT_CAP-1:0][7:0] comb_win;
    logic [PAT_CAP-1:0]      ok;
    logic [LEN_W-1:0]        base, span, sel, lits;
    logic                    match, accept;
    logic [CNT_W-1:0]        count_after;
    logic [TOT_W-1:0]        n_out;

    assign accept      = in_ch.valid && !full;
    assign in_ch.ready = !full;

    always_comb
    begin
        base = (fill_reg >= cfg.plen) ? '0 : fill_reg;
        comb_win = win_reg;
        comb_win[base[IDX_W-1:0]] = in_ch.in_byte;
        span = base + LEN_W'(1);

        // ok[s]: the window with s leading bytes dropped is a prefix of the pattern.
        for (int s = 0; s < PAT_CAP; s++)
        begin
            ok[s] = 1'b1;
            for (int j = 0; j < PAT_CAP - s; j++)
            begin
                if ((LEN_W'(s + j) < span) && (comb_win[s + j] != cfg.pat[j]))
                    ok[s] = 1'b0;
            end
        end

        sel = span;
        for (int s = PAT_CAP - 1; s >= 0; s--)
        begin
            if ((LEN_W'(s) < span) && ok[s])
                sel = LEN_W'(s);
        end

        match    = (sel == '0) && (span == cfg.plen);
        win_next = comb_win >> {sel, 3'b000};

        if (match)
        begin
            lits      = '0;
            fill_next = '0;
        end
        else
        begin
            lits      = sel;
            fill_next = span - sel;
        end

        // On the last byte whatever is still pending is flushed unchanged unless it completes a match.
        if (in_ch.is_last)
        begin
            lits      = match ? '0 : span;
            fill_next = '0;
        end

        n_out = TOT_W'(lits) + (match ? TOT_W'(cfg.rlen) : TOT_W'(0));

        count_after = (match && (count_reg != COUNT_MAX)) ? count_reg + CNT_W'(1)
                                                           : count_reg;
        count_next  = in_ch.is_last ? '0 : count_after;

        cmd.lit     = comb_win;
        cmd.lit_cnt = lits;
        cmd.rep     = match;
        cmd.last    = in_ch.is_last;
        cmd.count   = count_after;
    end

    assign push = accept && ((n_out != '0) || in_ch.is_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            count_reg <= '0;
        end
        else if (cfg.clear_window)
        begin
            fill_reg <= '0;
        end
        else if (accept)
        begin
            fill_reg  <= fill_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            win_reg <= win_next;
    end

    `BSFR_ASSERT(front_fill_below_plen, fill_reg < cfg.plen)
    `BSFR_NEVER(front_match_with_literals, push && cmd.rep && (cmd.lit_cnt != '0))

endmodule

`default_nettype wire

// File: hdl/bsfr_cmd_fifo.sv
// Short command queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
`include "byte_stream_find_replace_core_defines.svh"

module bsfr_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bsfr_pkg::cmd_t push_cmd,
    input  logic           pop,
    output bsfr_pkg::cmd_t head,
    output logic           not_empty,
    output logic           full
);
    import bsfr_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + QPTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + QPTR_W'(1);
        if (push && !pop)
            cnt_next = cnt_reg + QCNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    `BSFR_NEVER(fifo_push_when_full, push && full)
    `BSFR_NEVER(fifo_pop_when_empty, pop && !not_empty)

endmodule

`default_nettype wire

// File: hdl/bsfr_back.sv
// Back end: expands each queued command into output words through an output register.
`timescale 1ns / 1ps
`default_nettype none
`include "byte_stream_find_replace_core_defines.svh"

module bsfr_back (
    input  logic           clk,
    input  logic           rst_n,
    input  bsfr_pkg::cmd_t cmd,
    input  logic           cmd_valid,
    input  bsfr_pkg::cfg_t cfg,
    output logic           pop,
    bsfr_out_if.source     out_ch
);
    import bsfr_pkg::*;

    logic [TOT_W-1:0] idx_reg, idx_next;
    logic             ovalid_reg, ovalid_next;
    logic [7:0]       obyte_reg;
    logic             obval_reg, orun_reg, oeos_reg;
    logic [CNT_W-1:0] ocount_reg;

    logic [TOT_W-1:0] total, last_idx, ridx;
    logic             no_bytes, at_last, load;
    logic [7:0]       cur_byte;

    always_comb
    begin
        total    = TOT_W'(cmd.lit_cnt) + (cmd.rep ? TOT_W'(cfg.rlen) : TOT_W'(0));
        no_bytes = (total == '0);
        last_idx = no_bytes ? '0 : total - TOT_W'(1);
        at_last  = (idx_reg == last_idx);
        load     = cmd_valid && (!ovalid_reg || out_ch.ready);
        ridx     = idx_reg - TOT_W'(cmd.lit_cnt);

        if (no_bytes)
            cur_byte = '0;
        else if (idx_reg < TOT_W'(cmd.lit_cnt))
            cur_byte = cmd.lit[idx_reg[IDX_W-1:0]];
        else
            cur_byte = cfg.rep[ridx[RIDX_W-1:0]];

        idx_next = idx_reg;
        if (load)
            idx_next = at_last ? '0 : idx_reg + TOT_W'(1);

        if (load)
            ovalid_next = 1'b1;
        else if (out_ch.ready)
            ovalid_next = 1'b0;
        else
            ovalid_next = ovalid_reg;
    end

    assign pop = load && at_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            idx_reg    <= idx_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            obyte_reg  <= cur_byte;
            obval_reg  <= !no_bytes;
            orun_reg   <= at_last;
            oeos_reg   <= at_last && cmd.last;
            ocount_reg <= cmd.count;
        end
    end

    assign out_ch.valid             = ovalid_reg;
    assign out_ch.out_byte          = obyte_reg;
    assign out_ch.byte_valid        = obval_reg;
    assign out_ch.run_last          = orun_reg;
    assign out_ch.end_of_stream     = oeos_reg;
    assign out_ch.replacement_count = ocount_reg;

    `BSFR_NEVER(back_index_past_end, cmd_valid && (idx_reg > last_idx))

endmodule

`default_nettype wire

// File: hdl/byte_stream_find_replace_core.sv
// Top level of the byte stream find-and-replace core.
// Each input word carries one stream byte; every non-overlapping occurrence of
// the configured pattern (1 to 16 bytes) is replaced by the configured
// replacement (0 to 16 bytes) and all other bytes pass through in order. An
// input word is accepted every cycle as long as each byte causes at most one
// output word and the output side is ready; a byte that causes more than one
// output word holds the output side until all of them are taken, because the
// back end expands one word per cycle while the output side is ready, and a
// four-entry command queue lets the input run ahead of it. The first output
// word of a byte passes through the command queue and then the output register.
// Each output word carries the running, saturating replacement count; the word
// marked end_of_stream carries the final count, and the count starts again from
// zero for the next stream. Configuration must be written only while the core is
// idle; the core itself does not enforce this. Writing the pattern length drops
// any bytes still pending in the match window. There is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module byte_stream_find_replace_core (
    input  logic                             clk,
    input  logic                             rst_n,
    bsfr_in_if.sink                          in_ch,
    bsfr_out_if.source                       out_ch,
    input  logic                             cfg_we,
    input  logic [bsfr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bsfr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bsfr_pkg::*;

    cfg_t cfg;
    cmd_t push_cmd;
    cmd_t head_cmd;
    logic push;
    logic pop;
    logic full;
    logic not_empty;

    // Register file; also flags a pattern length write so the window is dropped.
    bsfr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The front end decides per byte which pending bytes leave as literals and
    // whether a full match fires, and pushes one command per productive or last byte.
    bsfr_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .cfg   (cfg),
        .full  (full),
        .push  (push),
        .cmd   (push_cmd)
    );

    // Decouples the two ends so each can stall on its own.
    bsfr_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .head      (head_cmd),
        .not_empty (not_empty),
        .full      (full)
    );

    // The back end walks each command one output word per cycle into the
    // output register, which keeps taking words while the sink is ready.
    bsfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head_cmd),
        .cmd_valid (not_empty),
        .cfg       (cfg),
        .pop       (pop),
        .out_ch    (out_ch)
    );

endmodule

`default_nettype wire
